// File: rtl/gcl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_pkg - G-code line tokenizer shared definitions
// Types, character codes and limits used by the tokenizer front, queue and back.
// ----------------------------------------------------------------------------
package gcl_pkg;

    localparam int LINE_MAX   = 64;
    localparam int WORD_MAX   = 10;
    localparam int POS_W      = $clog2(LINE_MAX + 1);
    localparam int SLOT_W     = $clog2(WORD_MAX + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam logic [5:0] FRAC_MAX = 6'd63;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_Z     = 8'h5A;

    typedef enum logic [1:0] {
        REC_WORD  = 2'd0,
        REC_DONE  = 2'd1,
        REC_EMPTY = 2'd2,
        REC_ERROR = 2'd3
    } rec_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_SIGN         = 3'd1,
        ERR_DOT          = 3'd2,
        ERR_LETTER_FIRST = 3'd3,
        ERR_BAD_CHAR     = 3'd4,
        ERR_N_LATE       = 3'd5,
        ERR_SECOND_CMD   = 3'd6,
        ERR_TOO_MANY     = 3'd7
    } err_code_t;

    // One queue entry: an optional word record followed by an optional end record
    typedef struct packed {
        logic        word_valid;
        logic [6:0]  letter;
        logic [31:0] mantissa;
        logic [5:0]  frac;
        logic [3:0]  word_index;
        logic        end_valid;
        rec_kind_t   end_kind;
        logic [3:0]  end_index;
        logic [3:0]  end_count;
        logic        end_term;
        err_code_t   end_err;
    } entry_t;

endpackage
`default_nettype wire

// File: rtl/gcl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_front - character parser
// Holds the line state, classifies each character and builds one queue entry.
// ----------------------------------------------------------------------------
module gcl_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    char_code,
    output gcl_pkg::entry_t    entry,
    output logic               entry_valid
);
    import gcl_pkg::*;

    logic              at_line_start_reg, at_line_start_next;
    logic              have_sign_reg, have_sign_next;
    logic              have_dot_reg, have_dot_next;
    logic              in_number_reg, in_number_next;
    logic              is_negative_reg, is_negative_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [6:0]        letter_reg, letter_next;
    logic [31:0]       man_reg, man_next;
    logic [5:0]        frac_reg, frac_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              discarding_reg, discarding_next;

    err_code_t         fail_code;
    logic              finish;
    logic              term;
    logic              new_line;
    logic              open_word;
    logic              emit_word;
    logic [31:0]       signed_man;
    logic [SLOT_W:0]   slot_inc;

    assign signed_man = is_negative_reg ? 32'(32'd0 - man_reg) : man_reg;
    assign slot_inc   = {1'b0, slot_reg} + 1'b1;

    always_comb
    begin
        at_line_start_next = at_line_start_reg;
        have_sign_next     = have_sign_reg;
        have_dot_next      = have_dot_reg;
        in_number_next     = in_number_reg;
        is_negative_next   = is_negative_reg;
        slot_next          = slot_reg;
        letter_next        = letter_reg;
        man_next           = man_reg;
        frac_next          = frac_reg;
        pos_next           = pos_reg;
        discarding_next    = discarding_reg;
        fail_code          = ERR_NONE;
        finish             = 1'b0;
        term               = 1'b0;
        new_line           = 1'b0;
        open_word          = 1'b0;
        emit_word          = 1'b0;

        if (discarding_reg)
        begin
            if (char_code == CH_NUL)
            begin
                discarding_next = 1'b0;
                new_line        = 1'b1;
            end
        end
        else if (pos_reg >= POS_W'(LINE_MAX))
        begin
            finish          = 1'b1;
            discarding_next = (char_code != CH_NUL);
            new_line        = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
            case (char_code) inside
                CH_NUL:
                begin
                    finish   = 1'b1;
                    new_line = 1'b1;
                end
                CH_SP, CH_TAB:
                begin
                end
                CH_CR, CH_LF, CH_SEMI, CH_STAR, CH_LPAR, CH_PCT, CH_SLASH:
                begin
                    finish          = 1'b1;
                    term            = 1'b1;
                    discarding_next = 1'b1;
                    new_line        = 1'b1;
                end
                CH_N:
                begin
                    if (!at_line_start_reg)
                        fail_code = ERR_N_LATE;
                end
                CH_G, CH_M:
                begin
                    if (!at_line_start_reg)
                        fail_code = ERR_SECOND_CMD;
                    else
                    begin
                        at_line_start_next = 1'b0;
                        slot_next          = '0;
                        open_word          = 1'b1;
                    end
                end
                CH_PLUS, CH_MINUS:
                begin
                    if (at_line_start_reg || have_sign_reg || in_number_reg)
                        fail_code = ERR_SIGN;
                    else
                    begin
                        have_sign_next   = 1'b1;
                        is_negative_next = (char_code == CH_MINUS);
                        in_number_next   = 1'b1;
                    end
                end
                CH_DOT:
                begin
                    if (at_line_start_reg || have_dot_reg)
                        fail_code = ERR_DOT;
                    else
                    begin
                        have_sign_next = 1'b1;
                        have_dot_next  = 1'b1;
                        in_number_next = 1'b1;
                    end
                end
                [CH_0:CH_9]:
                begin
                    if (!at_line_start_reg)
                    begin
                        have_sign_next = 1'b1;
                        in_number_next = 1'b1;
                        man_next = (man_reg << 3) + (man_reg << 1)
                                 + {28'd0, char_code[3:0]};
                        if (have_dot_reg && frac_reg < FRAC_MAX)
                            frac_next = frac_reg + 1'b1;
                    end
                end
                [CH_A:CH_Z]:
                begin
                    if (at_line_start_reg)
                        fail_code = ERR_LETTER_FIRST;
                    else if (slot_inc >= (SLOT_W + 1)'(WORD_MAX))
                        fail_code = ERR_TOO_MANY;
                    else
                    begin
                        emit_word = 1'b1;
                        slot_next = slot_inc[SLOT_W-1:0];
                        open_word = 1'b1;
                    end
                end
                default:
                    fail_code = ERR_BAD_CHAR;
            endcase
        end

        if (open_word)
        begin
            letter_next      = char_code[6:0];
            man_next         = '0;
            frac_next        = '0;
            have_sign_next   = 1'b0;
            have_dot_next    = 1'b0;
            in_number_next   = 1'b0;
            is_negative_next = 1'b0;
        end

        if (fail_code != ERR_NONE)
        begin
            discarding_next = 1'b1;
            new_line        = 1'b1;
        end

        if (new_line)
        begin
            at_line_start_next = 1'b1;
            have_sign_next     = 1'b0;
            have_dot_next      = 1'b0;
            in_number_next     = 1'b0;
            is_negative_next   = 1'b0;
            slot_next          = '0;
            letter_next        = '0;
            man_next           = '0;
            frac_next          = '0;
            pos_next           = '0;
        end
    end

    always_comb
    begin
        entry            = '0;
        entry.letter     = letter_reg;
        entry.mantissa   = signed_man;
        entry.frac       = frac_reg;
        entry.word_index = 4'(slot_reg);
        entry.end_kind   = REC_DONE;
        entry.end_err    = ERR_NONE;
        entry_valid      = 1'b0;
        if (fail_code != ERR_NONE)
        begin
            entry.end_valid = 1'b1;
            entry.end_kind  = REC_ERROR;
            entry.end_index = 4'(slot_reg);
            entry.end_err   = fail_code;
            entry_valid     = 1'b1;
        end
        else if (finish)
        begin
            entry.end_valid = 1'b1;
            entry.end_term  = term;
            entry_valid     = 1'b1;
            if (at_line_start_reg)
                entry.end_kind = REC_EMPTY;
            else
            begin
                entry.word_valid = 1'b1;
                entry.end_count  = 4'(slot_inc);
            end
        end
        else if (emit_word)
        begin
            entry.word_valid = 1'b1;
            entry_valid      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg <= 1'b1;
            have_sign_reg     <= 1'b0;
            have_dot_reg      <= 1'b0;
            in_number_reg     <= 1'b0;
            is_negative_reg   <= 1'b0;
            slot_reg          <= '0;
            letter_reg        <= '0;
            man_reg           <= '0;
            frac_reg          <= '0;
            pos_reg           <= '0;
            discarding_reg    <= 1'b0;
        end
        else if (accept)
        begin
            at_line_start_reg <= at_line_start_next;
            have_sign_reg     <= have_sign_next;
            have_dot_reg      <= have_dot_next;
            in_number_reg     <= in_number_next;
            is_negative_reg   <= is_negative_next;
            slot_reg          <= slot_next;
            letter_reg        <= letter_next;
            man_reg           <= man_next;
            frac_reg          <= frac_next;
            pos_reg           <= pos_next;
            discarding_reg    <= discarding_next;
        end
    end

    a_discard_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        discarding_reg |-> at_line_start_reg && pos_reg == '0)
        else $error("discarding outside a cleared line");

    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(LINE_MAX))
        else $error("character position past line limit");

    a_slot_limit: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, slot_reg} < (SLOT_W + 1)'(WORD_MAX))
        else $error("word slot past limit");

endmodule
`default_nettype wire

// File: rtl/gcl_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_fifo - entry queue
// Short queue between the parser and the record sequencer.
// ----------------------------------------------------------------------------
module gcl_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire gcl_pkg::entry_t wr_data,
    output logic               fifo_full,
    input  wire logic          rd_en,
    output gcl_pkg::entry_t    rd_data,
    output logic               fifo_empty
);
    import gcl_pkg::*;

    entry_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;

    assign fifo_full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign rd_data    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !fifo_full)
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !fifo_empty)
        else $error("read from empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

// File: rtl/gcl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_back - record sequencer
// Holds one entry and hands out its word and end records one per transfer.
// ----------------------------------------------------------------------------
module gcl_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire gcl_pkg::entry_t q_data,
    input  wire logic          q_empty,
    output logic               q_rd,
    input  wire logic          pop,
    output logic               empty,
    output logic [1:0]         rec_kind,
    output logic [6:0]         word_letter,
    output logic signed [31:0] mantissa,
    output logic [5:0]         frac_digits,
    output logic [3:0]         word_index,
    output logic [3:0]         word_count,
    output logic               by_terminator,
    output logic [2:0]         error_code,
    output logic               last
);
    import gcl_pkg::*;

    entry_t cur_reg;
    logic   cur_valid_reg;
    logic   word_done_reg;
    logic   show_word;
    logic   out_take;
    logic   finishing;

    assign show_word = cur_reg.word_valid && !word_done_reg;
    assign out_take  = pop && cur_valid_reg;
    assign finishing = !(show_word && cur_reg.end_valid);
    assign q_rd      = !q_empty && (!cur_valid_reg || (out_take && finishing));
    assign empty     = !cur_valid_reg;

    always_comb
    begin
        if (show_word)
        begin
            rec_kind      = REC_WORD;
            word_letter   = cur_reg.letter;
            mantissa      = cur_reg.mantissa;
            frac_digits   = cur_reg.frac;
            word_index    = cur_reg.word_index;
            word_count    = '0;
            by_terminator = 1'b0;
            error_code    = ERR_NONE;
            last          = !cur_reg.end_valid;
        end
        else
        begin
            rec_kind      = cur_reg.end_kind;
            word_letter   = '0;
            mantissa      = '0;
            frac_digits   = '0;
            word_index    = cur_reg.end_index;
            word_count    = cur_reg.end_count;
            by_terminator = cur_reg.end_term;
            error_code    = cur_reg.end_err;
            last          = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
            cur_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            word_done_reg <= 1'b0;
        end
        else if (q_rd)
        begin
            cur_valid_reg <= 1'b1;
            word_done_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (finishing)
                cur_valid_reg <= 1'b0;
            else
                word_done_reg <= 1'b1;
        end
    end

    a_has_record: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> cur_reg.word_valid || cur_reg.end_valid)
        else $error("held entry carries no record");

    a_word_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && word_done_reg |-> cur_reg.end_valid)
        else $error("word sent but no end record pending");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && !pop |=> cur_valid_reg && $stable(word_done_reg))
        else $error("record dropped while stalled");

endmodule
`default_nettype wire

// File: rtl/gcode_line_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcode_line_tokenizer - G-code line tokenizer
// Splits a stream of ASCII characters into word, line-done, empty-line and
// syntax-error records.
//
// Input channel: drive char_code with push high; the character transfers on a
// rising edge where full is low. One character can transfer every cycle while full is low.
// Output channel: while empty is low the oldest record is on the result ports;
// it transfers on a rising edge where pop is high. last marks the final record
// caused by one character.
// With the output side idle, a record becomes visible once the parser has
// written it into the queue at the transfer edge and the queue has loaded it
// into the output holding register.
// Throughput: one character per cycle while full is low; one record per cycle
// leaves while pop is high, so the extra record of a character that yields two
// records (word plus line done) is absorbed by the four-entry queue.
// A stalled receiver fills the queue, then full rises and input stops.
// Reset clears the line state, the queue and the output register's valid flag;
// no record is pending afterwards.
// ----------------------------------------------------------------------------
module gcode_line_tokenizer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    char_code,
    output logic               empty,
    input  wire logic          pop,
    output logic [1:0]         rec_kind,
    output logic [6:0]         word_letter,
    output logic signed [31:0] mantissa,
    output logic [5:0]         frac_digits,
    output logic [3:0]         word_index,
    output logic [3:0]         word_count,
    output logic               by_terminator,
    output logic [2:0]         error_code,
    output logic               last
);
    import gcl_pkg::*;

    entry_t front_entry;
    logic   front_valid;
    logic   accept;
    logic   q_full;
    logic   q_empty;
    logic   q_rd;
    entry_t q_data;

    assign full   = q_full;
    assign accept = push && !q_full;

    gcl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_code   (char_code),
        .entry       (front_entry),
        .entry_valid (front_valid)
    );

    gcl_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (accept && front_valid),
        .wr_data    (front_entry),
        .fifo_full  (q_full),
        .rd_en      (q_rd),
        .rd_data    (q_data),
        .fifo_empty (q_empty)
    );

    gcl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (q_data),
        .q_empty       (q_empty),
        .q_rd          (q_rd),
        .pop           (pop),
        .empty         (empty),
        .rec_kind      (rec_kind),
        .word_letter   (word_letter),
        .mantissa      (mantissa),
        .frac_digits   (frac_digits),
        .word_index    (word_index),
        .word_count    (word_count),
        .by_terminator (by_terminator),
        .error_code    (error_code),
        .last          (last)
    );

endmodule
`default_nettype wire
